### rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared types, codes and constants for the allocator and its cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Fixed field widths of the interface.
    localparam int OWNER_W  = 16;
    localparam int ORDER_W  = 5;
    localparam int REQ_W    = 31;
    localparam int TOTAL_W  = 7;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Size limits.
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int MAX_ORDER      = 30;
    localparam int SIZE_ORDER_CAP = 31;
    localparam int POW_W          = SIZE_ORDER_CAP + 1;

    typedef logic [OWNER_W-1:0] owner_t;
    typedef logic [ORDER_W-1:0] order_t;

    // One entry of the block list.
    typedef struct packed {
        owner_t owner;
        order_t order;
    } blk_t;

    // Operation applied to every cell of the chain together.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_SPLIT,
        CELL_GRANT,
        CELL_INIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        owner_t   grant_owner;
        order_t   init_order;
    } cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_SEARCH,
        ST_SPLIT,
        ST_GRANT,
        ST_RESTORE,
        ST_REPORT,
        ST_LIST
    } state_t;

    // Commands, result kinds, status codes, register index.
    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic REG_TOTAL_ORDER = 1'b0;

    // Limit a written order to the largest supported order.
    function automatic order_t clamp_order(input order_t value);
        order_t limit;
        limit = order_t'(MAX_ORDER);
        return (value > limit) ? limit : value;
    endfunction

    localparam order_t ORDER_RESET = clamp_order(order_t'(10));

endpackage

`default_nettype wire

### rtl/core/bba_cell.sv
// ----------------------------------------------------------------------------
// Buddy block allocator list cell
// Holds one block entry and updates it from its neighbors or the list head.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bba_pkg::cell_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]  last_idx,
    input  wire bba_pkg::blk_t     head_in,
    input  wire bba_pkg::blk_t     left_in,
    input  wire bba_pkg::blk_t     right_in,
    output bba_pkg::blk_t          blk
);

    bba_pkg::blk_t blk_reg;
    bba_pkg::blk_t blk_next;
    logic          is_tail;

    // The tail of the occupied list wraps around to the head on a rotate.
    assign is_tail = (IDX_W'(INDEX) == last_idx);

    // Next entry value for each chain operation.
    always_comb
    begin
        blk_next = blk_reg;
        unique case (ctrl.op)
            bba_pkg::CELL_ROTATE:
            begin
                blk_next = is_tail ? head_in : right_in;
            end
            bba_pkg::CELL_SPLIT:
            begin
                if (INDEX == 0)
                begin
                    blk_next.order = bba_pkg::order_t'(blk_reg.order - 1'b1);
                end
                else if (INDEX == 1)
                begin
                    blk_next.owner = '0;
                    blk_next.order = bba_pkg::order_t'(head_in.order - 1'b1);
                end
                else
                begin
                    blk_next = left_in;
                end
            end
            bba_pkg::CELL_GRANT:
            begin
                if (INDEX == 0)
                begin
                    blk_next.owner = ctrl.grant_owner;
                end
            end
            bba_pkg::CELL_INIT:
            begin
                if (INDEX == 0)
                begin
                    blk_next.owner = '0;
                    blk_next.order = ctrl.init_order;
                end
            end
            default:
            begin
                blk_next = blk_reg;
            end
        endcase
    end

    // Entry storage; the head cell comes out of reset as one free block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg.owner <= '0;
            blk_reg.order <= (INDEX == 0) ? bba_pkg::ORDER_RESET : '0;
        end
        else
        begin
            blk_reg <= blk_next;
        end
    end

    assign blk = blk_reg;

endmodule

`default_nettype wire

### rtl/core/bba_chain.sv
// ----------------------------------------------------------------------------
// Buddy block allocator cell chain
// A row of list cells; the head entry is the only one seen from outside.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_chain #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bba_pkg::cell_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]    last_idx,
    output bba_pkg::blk_t            head
);

    bba_pkg::blk_t blk_w [MAX_BLOCKS];

    // Each cell sees its two neighbors and the head of the list.
    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        bba_pkg::blk_t left_w;
        bba_pkg::blk_t right_w;

        if (k == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_left
            assign left_w = blk_w[k-1];
        end

        if (k == MAX_BLOCKS - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_right
            assign right_w = blk_w[k+1];
        end

        bba_cell #(
            .INDEX (k),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .last_idx (last_idx),
            .head_in  (blk_w[0]),
            .left_in  (left_w),
            .right_in (right_w),
            .blk      (blk_w[k])
        );
    end

    assign head = blk_w[0];

endmodule

`default_nettype wire

### rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Keeps an ordered list of power-of-two blocks in a chain of cells, grants
// blocks by splitting the first free one that fits, and lists all blocks.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                    Payload
//  -------  ---------------------------  ----------------------------------
//  config   psel/penable/pwrite, pready  paddr, pwdata, prdata (total_order)
//  input    in_valid / in_ready          command, owner_id, request_size
//  output   out_valid / out_ready        result_kind, status, block_total,
//                                        entry_owner, entry_order, last
//
// One word is handled at a time; in_ready is high only while the sequencer idles.
// The list is rotated through the head cell one entry per cycle. An allocate
// word goes through the size steps, the search steps, the splits, the grant,
// the rotations back to the original order and the report. Search and restore
// together make one pass around the list of N blocks.
// A query word gives one result per cycle per block while out_ready is high.
// A result waits in the output register; a stalled output halts the listing.
// No clearing pass after reset: the list is one free block at once.
`default_nettype none

module buddy_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bba_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bba_pkg::DATA_W-1:0]    pwdata,
    output logic [bba_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // Input words
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          command,
    input  wire logic [bba_pkg::OWNER_W-1:0]   owner_id,
    input  wire logic [bba_pkg::REQ_W-1:0]     request_size,
    // Result words
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               result_kind,
    output logic [bba_pkg::STATUS_W-1:0]       status,
    output logic [bba_pkg::TOTAL_W-1:0]        block_total,
    output logic [bba_pkg::OWNER_W-1:0]        entry_owner,
    output logic [bba_pkg::ORDER_W-1:0]        entry_order,
    output logic                               last
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ((CNT_W > bba_pkg::ORDER_W) ? CNT_W : bba_pkg::ORDER_W) + 1;

    // Sequencer and datapath registers.
    bba_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            step_reg;
    bba_pkg::order_t             d_reg;
    logic [bba_pkg::POW_W-1:0]   pow_reg;
    logic [bba_pkg::REQ_W-1:0]   req_reg;
    bba_pkg::owner_t             owner_reg;
    logic [bba_pkg::STATUS_W-1:0] code_reg;
    bba_pkg::order_t             total_order_reg;

    // Output register.
    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [bba_pkg::STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]            out_total_reg;
    bba_pkg::owner_t             out_owner_reg;
    bba_pkg::order_t             out_order_reg;
    logic                        out_last_reg;

    // Control decoded from the state.
    bba_pkg::cell_ctrl_t         cell_ctrl;
    bba_pkg::blk_t               head;
    logic                        in_fire;
    logic                        cfg_we;
    logic                        out_free;
    logic                        size_done;
    logic                        head_fit;
    logic                        table_full;
    logic                        split_last;
    logic                        step_at_end;
    logic                        list_last;
    logic [SUM_W-1:0]            need_total;
    logic [IDX_W-1:0]            last_idx;
    logic                        step_inc;
    logic                        count_inc;
    logic                        out_load;
    logic                        set_nofit;
    logic                        set_full;
    logic                        set_ok;

    // Handshake and configuration decode.
    assign pready   = 1'b1;
    assign in_ready = (state_reg == bba_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign cfg_we   = psel && penable && pwrite && (paddr[2] == bba_pkg::REG_TOTAL_ORDER);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        prdata = '0;
        if (psel && (paddr[2] == bba_pkg::REG_TOTAL_ORDER))
        begin
            prdata = bba_pkg::DATA_W'(total_order_reg);
        end
    end

    // Conditions seen at the list head.
    assign last_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign size_done   = (d_reg == bba_pkg::order_t'(bba_pkg::SIZE_ORDER_CAP)) ||
                         (pow_reg >= bba_pkg::POW_W'(req_reg));
    assign head_fit    = (head.owner == '0) && (head.order >= d_reg);
    assign need_total  = SUM_W'(count_reg) + SUM_W'(bba_pkg::order_t'(head.order - d_reg));
    assign table_full  = need_total > SUM_W'(MAX_BLOCKS);
    assign split_last  = (bba_pkg::order_t'(head.order - 1'b1) == d_reg);
    assign step_at_end = (step_reg == count_reg);
    assign list_last   = (step_reg == count_reg - CNT_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (command == bba_pkg::CMD_QUERY) ? bba_pkg::ST_LIST
                                                                 : bba_pkg::ST_SIZE;
                end
            end
            bba_pkg::ST_SIZE:
            begin
                if (size_done)
                begin
                    state_next = bba_pkg::ST_SEARCH;
                end
            end
            bba_pkg::ST_SEARCH:
            begin
                if (head_fit)
                begin
                    if (table_full)
                    begin
                        state_next = bba_pkg::ST_RESTORE;
                    end
                    else if (head.order == d_reg)
                    begin
                        state_next = bba_pkg::ST_GRANT;
                    end
                    else
                    begin
                        state_next = bba_pkg::ST_SPLIT;
                    end
                end
                else if (list_last)
                begin
                    state_next = bba_pkg::ST_RESTORE;
                end
            end
            bba_pkg::ST_SPLIT:
            begin
                if (split_last)
                begin
                    state_next = bba_pkg::ST_GRANT;
                end
            end
            bba_pkg::ST_GRANT:
            begin
                state_next = bba_pkg::ST_RESTORE;
            end
            bba_pkg::ST_RESTORE:
            begin
                if (step_at_end)
                begin
                    state_next = bba_pkg::ST_REPORT;
                end
            end
            bba_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_LIST:
            begin
                if (out_free && list_last)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        cell_ctrl.op          = bba_pkg::CELL_HOLD;
        cell_ctrl.grant_owner = owner_reg;
        cell_ctrl.init_order  = bba_pkg::clamp_order(pwdata[bba_pkg::ORDER_W-1:0]);
        step_inc  = 1'b0;
        count_inc = 1'b0;
        out_load  = 1'b0;
        set_nofit = 1'b0;
        set_full  = 1'b0;
        set_ok    = 1'b0;
        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (cfg_we)
                begin
                    cell_ctrl.op = bba_pkg::CELL_INIT;
                end
            end
            bba_pkg::ST_SEARCH:
            begin
                if (head_fit)
                begin
                    set_full = table_full;
                end
                else
                begin
                    cell_ctrl.op = bba_pkg::CELL_ROTATE;
                    step_inc     = 1'b1;
                    set_nofit    = list_last;
                end
            end
            bba_pkg::ST_SPLIT:
            begin
                cell_ctrl.op = bba_pkg::CELL_SPLIT;
                count_inc    = 1'b1;
            end
            bba_pkg::ST_GRANT:
            begin
                cell_ctrl.op = bba_pkg::CELL_GRANT;
                set_ok       = 1'b1;
            end
            bba_pkg::ST_RESTORE:
            begin
                if (!step_at_end)
                begin
                    cell_ctrl.op = bba_pkg::CELL_ROTATE;
                    step_inc     = 1'b1;
                end
            end
            bba_pkg::ST_REPORT:
            begin
                out_load = out_free;
            end
            bba_pkg::ST_LIST:
            begin
                if (out_free)
                begin
                    cell_ctrl.op = bba_pkg::CELL_ROTATE;
                    step_inc     = 1'b1;
                    out_load     = 1'b1;
                end
            end
            default:
            begin
                cell_ctrl.op = bba_pkg::CELL_HOLD;
            end
        endcase
    end

    // Row of list cells.
    bba_chain #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .last_idx (last_idx),
        .head     (head)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bba_pkg::ST_IDLE;
            count_reg       <= CNT_W'(1);
            step_reg        <= '0;
            total_order_reg <= bba_pkg::ORDER_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (state_reg == bba_pkg::ST_IDLE))
            begin
                total_order_reg <= bba_pkg::clamp_order(pwdata[bba_pkg::ORDER_W-1:0]);
                count_reg       <= CNT_W'(1);
            end
            else if (count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (in_fire)
            begin
                step_reg <= '0;
            end
            else if (step_inc)
            begin
                step_reg <= step_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request size to order, one doubling per cycle, and the result status code.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            owner_reg <= owner_id;
            req_reg   <= request_size;
            d_reg     <= '0;
            pow_reg   <= bba_pkg::POW_W'(1);
        end
        else if ((state_reg == bba_pkg::ST_SIZE) && !size_done)
        begin
            d_reg   <= bba_pkg::order_t'(d_reg + 1'b1);
            pow_reg <= {pow_reg[bba_pkg::POW_W-2:0], 1'b0};
        end
        if (set_nofit)
        begin
            code_reg <= bba_pkg::STATUS_NOFIT;
        end
        else if (set_full)
        begin
            code_reg <= bba_pkg::STATUS_FULL;
        end
        else if (set_ok)
        begin
            code_reg <= bba_pkg::STATUS_OK;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_total_reg <= count_reg;
            if (state_reg == bba_pkg::ST_LIST)
            begin
                out_kind_reg   <= bba_pkg::KIND_ENTRY;
                out_status_reg <= bba_pkg::STATUS_OK;
                out_owner_reg  <= head.owner;
                out_order_reg  <= head.order;
                out_last_reg   <= list_last;
            end
            else
            begin
                out_kind_reg   <= bba_pkg::KIND_ALLOC;
                out_status_reg <= code_reg;
                out_owner_reg  <= '0;
                out_order_reg  <= (code_reg == bba_pkg::STATUS_OK) ? d_reg : '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign status      = out_status_reg;
    assign block_total = bba_pkg::TOTAL_W'(out_total_reg);
    assign entry_owner = out_owner_reg;
    assign entry_order = out_order_reg;
    assign last        = out_last_reg;

    // The block count always stays within the list depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");

    // A listing never runs past the occupied part of the list.
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_LIST) |-> (step_reg < count_reg))
        else $error("listing step beyond block count");

    // Only a free block larger than the request is ever split.
    a_split_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_SPLIT) |-> ((head.owner == '0) && (head.order > d_reg)))
        else $error("split of an unsuitable block");

    // After a split the count has grown by exactly one.
    a_split_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_SPLIT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("split did not add one block");

endmodule

`default_nettype wire

### sim/tb_buddy_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and query words with random gaps and output stalls. Every
// accepted word goes to a scoreboard. The scoreboard keeps its own copy of the
// block list, predicts each result word, and checks the words that come out
// in order. The region size is changed between phases over the config port.
// ----------------------------------------------------------------------------

module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int LIST_DEPTH    = MAX_BLOCKS_DEF;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 40;
    localparam int QUERY_PCT     = 12;
    localparam int SHOWN_ERRORS  = 10;

    // Register map: total_order is the only register; the next slot is unmapped.
    localparam logic [ADDR_W-1:0] ADDR_TOTAL_ORDER = ADDR_W'(4 * REG_TOTAL_ORDER);
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_W'(4 * (REG_TOTAL_ORDER + 1));

    // Request size mix for a random phase.
    typedef enum int {
        MIX_WIDE,
        MIX_TINY
    } size_mix_t;

    // One result word, in port order.
    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
        owner_t              owner;
        order_t              order;
        logic                last;
    } alloc_word_t;

    // Block list predictor and the queue of result words it expects.
    class allocator_scoreboard;
        order_t      region_order;
        owner_t      own_tbl[LIST_DEPTH];
        order_t      ord_tbl[LIST_DEPTH];
        int          blk_cnt;
        alloc_word_t expected_q[$];
        int          mismatches;
        int          seen_words;

        function new();
            region_order = ORDER_RESET;
            mismatches = 0;
            seen_words = 0;
            rebuild();
        endfunction

        // The list collapses to one free block spanning the whole region.
        function void rebuild();
            int k;
            for (k = 0; k < LIST_DEPTH; k++)
            begin
                own_tbl[k] = '0;
                ord_tbl[k] = '0;
            end
            ord_tbl[0] = region_order;
            blk_cnt = 1;
        endfunction

        // A register write keeps the low five bits and saturates at the top order.
        function void set_region(input logic [DATA_W-1:0] wdata);
            order_t value;
            value = wdata[ORDER_W-1:0];
            region_order = (int'(value) > MAX_ORDER) ? order_t'(MAX_ORDER) : value;
            rebuild();
        endfunction

        function void note_failure(input string msg);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // Smallest order whose size covers the request; zero and one give order 0.
        function int round_up_order(input logic [REQ_W-1:0] req);
            int d;
            d = 0;
            while (d < 31 && (64'd1 << d) < {33'd0, req})
                d++;
            return d;
        endfunction

        // An accepted input word: update the list and queue the expected results.
        function void note_word(input logic cmd, input owner_t who,
                                input logic [REQ_W-1:0] req);
            alloc_word_t r;
            int          d;
            int          pick;
            int          k;
            if (cmd == CMD_QUERY)
            begin
                for (k = 0; k < blk_cnt; k++)
                begin
                    r.kind   = KIND_ENTRY;
                    r.status = STATUS_OK;
                    r.total  = TOTAL_W'(blk_cnt);
                    r.owner  = own_tbl[k];
                    r.order  = ord_tbl[k];
                    r.last   = (k + 1 == blk_cnt);
                    expected_q.push_back(r);
                end
                return;
            end
            d = round_up_order(req);
            pick = -1;
            for (k = 0; k < blk_cnt; k++)
            begin
                if (pick < 0 && own_tbl[k] == '0 && int'(ord_tbl[k]) >= d)
                    pick = k;
            end
            r.kind  = KIND_ALLOC;
            r.owner = '0;
            r.order = '0;
            r.last  = 1'b1;
            if (pick < 0)
                r.status = STATUS_NOFIT;
            else if (blk_cnt + int'(ord_tbl[pick]) - d > LIST_DEPTH)
                r.status = STATUS_FULL;
            else
            begin
                // Halve the chosen block, the upper half going right behind it.
                while (int'(ord_tbl[pick]) > d)
                begin
                    for (k = blk_cnt; k > pick + 1; k--)
                    begin
                        own_tbl[k] = own_tbl[k-1];
                        ord_tbl[k] = ord_tbl[k-1];
                    end
                    ord_tbl[pick] = ord_tbl[pick] - 1'b1;
                    own_tbl[pick+1] = own_tbl[pick];
                    ord_tbl[pick+1] = ord_tbl[pick];
                    blk_cnt++;
                end
                own_tbl[pick] = who;
                r.status = STATUS_OK;
                r.order  = order_t'(d);
            end
            r.total = TOTAL_W'(blk_cnt);
            expected_q.push_back(r);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
                note_failure($sformatf("result word %0d: %s expected 0x%0h, got 0x%0h",
                                       seen_words, name, want, got));
        endfunction

        // An accepted result word against the oldest expectation.
        function void check_word(input alloc_word_t got);
            alloc_word_t want;
            seen_words++;
            if (expected_q.size() == 0)
            begin
                note_failure($sformatf({"result word %0d with nothing expected: kind %0d",
                                        " status %0d total %0d owner 0x%0h order %0d last %0d"},
                                       seen_words, got.kind, got.status, got.total,
                                       got.owner, got.order, got.last));
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("status", want.status, got.status);
            compare_field("block_total", want.total, got.total);
            compare_field("entry_owner", want.owner, got.owner);
            compare_field("entry_order", want.order, got.order);
            compare_field("last", want.last, got.last);
        endfunction

        function void check_leftovers();
            if (expected_q.size() != 0)
                note_failure($sformatf("%0d expected result words never came",
                                       expected_q.size()));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 command = CMD_ALLOC;
    owner_t               owner_id = '0;
    logic [REQ_W-1:0]     request_size = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 result_kind;
    logic [STATUS_W-1:0]  status;
    logic [TOTAL_W-1:0]   block_total;
    owner_t               entry_owner;
    order_t               entry_order;
    logic                 last;

    allocator_scoreboard board;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   hold_left = 0;
    int                   cycles = 0;

    buddy_block_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .owner_id     (owner_id),
        .request_size (request_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .status       (status),
        .block_total  (block_total),
        .entry_owner  (entry_owner),
        .entry_order  (entry_order),
        .last         (last)
    );

    always #2 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL buddy_block_allocator");
            $finish;
        end
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_word(command, owner_id, request_size);
            if (out_valid && out_ready)
                board.check_word(alloc_word_t'({result_kind, status, block_total,
                                                entry_owner, entry_order, last}));
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random output stalls.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_ready = 1'b0;
            hold_left = pick_gap() - 1;
        end
        else
            out_ready = 1'b1;
    end

    function automatic owner_t rand_owner();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return '1;
        return owner_t'($urandom_range(1, 65535));
    endfunction

    // Tiny sizes fill the table; the wide mix covers rounding and misfits.
    function automatic logic [REQ_W-1:0] rand_request(input int region, input size_mix_t mix);
        int               pick;
        int               d;
        logic [REQ_W-1:0] unit;
        pick = $urandom_range(0, 99);
        d = $urandom_range(0, region);
        unit = REQ_W'(64'd1 << d);
        if (mix == MIX_TINY)
        begin
            if (pick < 85)
                return REQ_W'($urandom_range(0, 1));
            return REQ_W'($urandom_range(2, 4));
        end
        if (pick < 30)
            return REQ_W'($urandom_range(1, 8));
        if (pick < 50)
            return unit;
        if (pick < 65)
            return unit + 1'b1;
        if (pick < 80)
            return REQ_W'($urandom_range(1, 32'(unit)));
        if (pick < 87)
            return '0;
        return REQ_W'($urandom());
    endfunction

    // All tasks below start and end at a falling edge.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_TOTAL_ORDER)
            board.set_region(data);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_check_order();
        logic [DATA_W-1:0] seen;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_TOTAL_ORDER;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        seen = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (seen != DATA_W'(board.region_order))
            board.note_failure($sformatf("total_order read expected %0d, got %0d",
                                         board.region_order, seen));
    endtask

    // One input word, with an optional gap ahead of it.
    task automatic send_word(input logic cmd, input owner_t who, input logic [REQ_W-1:0] req);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
        command = cmd;
        owner_id = who;
        request_size = req;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every expected word has come and the sequencer has settled.
    task automatic drain();
        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] wdata, input size_mix_t mix,
                             input int words);
        int region;
        int n;
        drain();
        apb_write(ADDR_TOTAL_ORDER, wdata);
        apb_check_order();
        region = int'(board.region_order);
        case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 15;
            default: stall_pct = 40;
        endcase
        for (n = 0; n < words; n++)
        begin
            if ($urandom_range(0, 99) < QUERY_PCT)
                send_word(CMD_QUERY, rand_owner(), rand_request(region, mix));
            else
                send_word(CMD_ALLOC, rand_owner(), rand_request(region, mix));
        end
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset state, rounding, owner extremes, and requests too large to fit.
        apb_check_order();
        send_word(CMD_QUERY, '0, '0);
        send_word(CMD_ALLOC, '1, REQ_W'(1));
        send_word(CMD_ALLOC, owner_t'(1), '0);
        send_word(CMD_ALLOC, '0, REQ_W'(2));
        send_word(CMD_ALLOC, owner_t'(16'h8000), REQ_W'(3));
        send_word(CMD_ALLOC, owner_t'(16'h1234), '1);
        send_word(CMD_ALLOC, owner_t'(16'h4321), REQ_W'(1) << 30);
        send_word(CMD_QUERY, '1, '1);

        // A write to the unmapped slot must leave the list alone.
        drain();
        apb_write(ADDR_UNMAPPED, DATA_W'(5));
        apb_check_order();
        send_word(CMD_QUERY, '0, '0);

        // An order above the maximum saturates; the whole region is granted at once.
        drain();
        apb_write(ADDR_TOTAL_ORDER, DATA_W'(31));
        apb_check_order();
        send_word(CMD_ALLOC, owner_t'(16'haaaa), REQ_W'(1) << 30);
        send_word(CMD_ALLOC, owner_t'(2), REQ_W'(1));
        send_word(CMD_QUERY, '0, '0);

        // Deepest split chain, then reuse of the free buddy.
        drain();
        apb_write(ADDR_TOTAL_ORDER, DATA_W'(MAX_ORDER));
        send_word(CMD_ALLOC, owner_t'(16'h5555), REQ_W'(1));
        send_word(CMD_ALLOC, owner_t'(3), REQ_W'(1));
        send_word(CMD_ALLOC, owner_t'(4), (REQ_W'(1) << 29) + 1'b1);
        send_word(CMD_QUERY, '0, '0);

        // Smallest region: one unit.
        drain();
        apb_write(ADDR_TOTAL_ORDER, '0);
        apb_check_order();
        send_word(CMD_ALLOC, owner_t'(7), REQ_W'(1));
        send_word(CMD_ALLOC, owner_t'(8), REQ_W'(1));
        send_word(CMD_QUERY, '0, '0);

        // Random phases; tiny requests on small regions run the table full.
        run_phase(DATA_W'(8), MIX_TINY, 60);
        run_phase(DATA_W'(10), MIX_WIDE, 35);
        run_phase('0, MIX_WIDE, 15);
        run_phase({$urandom()} | DATA_W'(31), MIX_WIDE, 35);
        run_phase(DATA_W'(12), MIX_TINY, 50);
        run_phase(DATA_W'(1), MIX_WIDE, 15);
        run_phase(DATA_W'(20), MIX_WIDE, 35);
        run_phase(DATA_W'(7), MIX_TINY, 70);

        drain();
        board.check_leftovers();
        if (board.mismatches == 0)
            $display("PASS buddy_block_allocator");
        else
            $display("FAIL buddy_block_allocator");
        $finish;
    end

endmodule

### buddy_block_allocator.f
rtl/core/bba_pkg.sv
rtl/core/bba_cell.sv
rtl/core/bba_chain.sv
rtl/core/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
